// File: hw/rtl/assert_macros.svh
// Assertion helpers for RTL that checks its own logic, as the encoder unit does.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define B64E_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");

// Consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hw/rtl/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] code_char;
      logic       last_char;
   } rsp_payload_type;

   // One three-byte group, zero-filled, with the number of real characters.
   typedef struct packed {
      logic [23:0] bits;
      logic [2:0]  nchar;
      logic        last;
   } group_type;

   typedef struct packed {
      logic [1:0] pend_count;
   } front_stat_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      c = 8'h00;
      case (v) inside
         [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
         [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
         [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
         6'd62:         c = 8'h2B;
         default:       c = 8'h2F;
      endcase
      return c;
   endfunction

endpackage

// File: hw/rtl/b64e_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_req_if
// Byte input channel: valid/ready handshake with a raw byte payload.
// ----------------------------------------------------------------------------
interface b64e_req_if
   import b64e_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/b64e_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_rsp_if
// Character output channel: valid/ready handshake with an ASCII payload.
// ----------------------------------------------------------------------------
interface b64e_rsp_if
   import b64e_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Collects bytes into groups of three, or fewer at a message end, and pushes them.
// ----------------------------------------------------------------------------
module b64e_front
   import b64e_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   b64e_req_if.sink       req_if,
   output logic           push_valid,
   input  logic           push_ready,
   output group_type      push_group,
   output front_stat_type stat
);

   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic       accept;
   logic       hold;
   logic [7:0] b0, b1, b2;

   assign req_if.ready = push_ready;
   assign accept       = req_if.valid && push_ready;
   // byte only waits when the group is open and the message continues
   assign hold         = (cnt_ff < 2'd2) && !req_if.payload.last_byte;
   assign push_valid   = req_if.valid && !hold;

   always_comb begin
      b0 = (cnt_ff != 2'd0) ? pend0_ff : req_if.payload.data_byte;
      b1 = (cnt_ff == 2'd2) ? pend1_ff
         : ((cnt_ff == 2'd1) ? req_if.payload.data_byte : 8'h00);
      b2 = (cnt_ff == 2'd2) ? req_if.payload.data_byte : 8'h00;
      push_group.bits  = {b0, b1, b2};
      push_group.nchar = {1'b0, cnt_ff} + 3'd2;
      push_group.last  = req_if.payload.last_byte;
   end

   always_comb begin
      cnt_in   = cnt_ff;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      if (accept) begin
         if (hold) begin
            if (cnt_ff == 2'd0) begin
               pend0_in = req_if.payload.data_byte;
            end else begin
               pend1_in = req_if.payload.data_byte;
            end
            cnt_in = cnt_ff + 2'd1;
         end else begin
            cnt_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

   assign stat.pend_count = cnt_ff;

endmodule

// File: hw/rtl/b64e_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Small FIFO of finished groups between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue
   import b64e_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  group_type push_group,
   output logic      pop_valid,
   input  logic      pop_ready,
   output group_type pop_group
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_group  = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

// File: hw/rtl/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Emits each group's four characters via an output reg, one per cycle if ready.
// ----------------------------------------------------------------------------
module b64e_back
   import b64e_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  group_type pop_group,
   b64e_rsp_if.source rsp_if
);

   group_type  group_ff, group_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;
   logic       out_load;
   logic       done;
   logic [5:0] sext;

   assign out_load  = busy_ff && (!out_valid_ff || rsp_if.ready);
   assign done      = out_load && (idx_ff == 2'd3);
   assign pop_ready = !busy_ff || done;

   always_comb begin
      case (idx_ff)
         2'd0:    sext = group_ff.bits[23:18];
         2'd1:    sext = group_ff.bits[17:12];
         2'd2:    sext = group_ff.bits[11:6];
         default: sext = group_ff.bits[5:0];
      endcase
   end

   always_comb begin
      group_in     = group_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
         // positions past the real characters become padding
         out_char_in  = ({1'b0, idx_ff} < group_ff.nchar) ? b64_char(sext) : PAD_CHAR;
         out_last_in  = group_ff.last && (idx_ff == 2'd3);
         idx_in       = idx_ff + 2'd1;
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         group_in = pop_group;
         busy_in  = 1'b1;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      group_ff    <= group_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.payload.code_char = out_char_ff;
   assign rsp_if.payload.last_char = out_last_ff;

endmodule

// File: hw/rtl/base64_stream_encoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// Streaming base64 encoder: raw bytes in, ASCII characters out.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one raw byte per beat plus last_byte on the final byte of
//   a message. rsp_if carries one ASCII character per beat; last_char marks
//   the final character of the message, '=' padding included.
//   Every three bytes (or the last byte of a message) form a group that is
//   turned into four characters. Bytes that do not finish a group are taken
//   one per cycle while the queue has room and produce nothing on their own.
//   A completed group goes through the queue and the group register of the
//   character stage into the output register, where its first character is
//   valid; the other three follow one per cycle while rsp_if.ready is high.
//   Throughput: the character stage sends one character per cycle while it
//   is not stalled. A group queue of QUEUE_DEPTH entries sits between the
//   byte collector and the character stage.
//   Stall: when rsp_if.ready is low the output register holds; the byte
//   collector and the group queue keep taking bytes until the queue is full,
//   then req_if.ready drops. Reset (synchronous, active high) drops any
//   partial group, empties the queue and clears the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_stream_encoder_unit
   import b64e_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req_if,
   b64e_rsp_if.source  rsp_if
);

   logic           push_valid, push_ready;
   group_type      push_group;
   logic           pop_valid, pop_ready;
   group_type      pop_group;
   front_stat_type front_stat;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group),
      .stat       (front_stat)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_group  (pop_group)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_group (pop_group),
      .rsp_if    (rsp_if)
   );

   `B64E_ASSERT_ALWAYS(a_count_range, clock, reset, front_stat.pend_count != 2'd3)
   `B64E_ASSERT_NEXT(a_last_clears, clock, reset, req_if.valid && req_if.ready && req_if.payload.last_byte, front_stat.pend_count == 2'd0)
   `B64E_ASSERT_NEXT(a_byte_held, clock, reset, req_if.valid && req_if.ready && !req_if.payload.last_byte && front_stat.pend_count != 2'd2, front_stat.pend_count == $past(front_stat.pend_count) + 2'd1)

endmodule

// File: bench/base64_stream_encoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit_test
// Self-checking bench for the streaming base64 encoder. Byte messages are
// queued up front, a short directed set and then random messages. A clocked
// driver sends them with random gaps. A byte encoder in the bench keeps its
// own partial group and predicts every character. A clocked monitor
// back-pressures at random, including one long hold, and checks each
// character in order.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit_test;
   import b64e_pkg::*;

   localparam logic [8*64-1:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [7:0] data;
      logic       fin;
      int         gap;
      bit         drain_first;   // hold until every due character is back
   } byte_beat_type;

   logic clock;
   logic reset;

   b64e_req_if req_bus ();
   b64e_rsp_if rsp_bus ();

   base64_stream_encoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   byte_beat_type   bytes_to_send[$];
   rsp_payload_type char_due[$];

   // encoder state as the bench sees it
   logic [7:0] held_bytes [2];
   logic [1:0] held_count;

   byte_beat_type cur_beat;
   bit            have_beat;
   int            gap_left;
   int            bytes_taken;
   int            rsp_wait;
   bit            rsp_calm;
   logic          rsp_hold;
   int            mismatches;

   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      logic [1:0]      n;
      logic [23:0]     grp;
      logic [5:0]      sextet;
      rsp_payload_type ch;
      n = (held_count == 2'd3) ? 2'd2 : held_count;
      if (n < 2'd2 && !fin) begin
         held_bytes[n] = b;
         held_count = n + 2'd1;
         return;
      end
      grp[23:16] = (n >= 2'd1) ? held_bytes[0] : b;
      grp[15:8]  = (n == 2'd2) ? held_bytes[1] : ((n == 2'd1) ? b : 8'h00);
      grp[7:0]   = (n == 2'd2) ? b : 8'h00;
      for (int k = 0; k < 4; k++) begin
         sextet = grp[23 - 6*k -: 6];
         ch.code_char = (k < int'(n) + 2) ? B64_ALPHABET[8*(63 - sextet) +: 8] : PAD_CHAR;
         ch.last_char = fin && (k == 3);
         char_due = {char_due, ch};
      end
      held_count = 2'd0;
   endfunction

   task automatic queue_byte(input logic [7:0] data, input logic fin, input bit calm,
                             input bit drain);
      byte_beat_type bt;
      bt.data        = data;
      bt.fin         = fin;
      bt.gap         = calm ? 0 : $urandom_range(0, 3);
      bt.drain_first = drain;
      bytes_to_send = {bytes_to_send, bt};
   endtask

   task automatic queue_message(input int len, input bit calm, input bit drain);
      for (int i = 0; i < len; i++)
         queue_byte(8'($urandom_range(0, 255)), i == len - 1, calm, drain && i == 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // sender: a new beat only goes out once the current one has been taken
   always @(posedge clock) begin : drive_bytes
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.payload <= '0;
         have_beat   = 1'b0;
         gap_left    = 0;
         bytes_taken = 0;
         held_bytes[0] = 8'h00;
         held_bytes[1] = 8'h00;
         held_count  = 2'd0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            encode_byte(req_bus.payload.data_byte, req_bus.payload.last_byte);
            bytes_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (!have_beat && bytes_to_send.size() > 0 &&
                (!bytes_to_send[0].drain_first || char_due.size() == 0)) begin
               cur_beat  = bytes_to_send.pop_front();
               have_beat = 1'b1;
               gap_left  = cur_beat.gap;
            end
            if (have_beat && gap_left == 0) begin
               req_bus.valid   <= 1'b1;
               req_bus.payload <= {cur_beat.data, cur_beat.fin};
               have_beat = 1'b0;
            end else begin
               req_bus.valid <= 1'b0;
               if (have_beat)
                  gap_left--;
            end
         end
      end
   end

   // receiver: checks each character beat against the oldest prediction
   always @(posedge clock) begin : watch_chars
      rsp_payload_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait   = 0;
         rsp_calm   = 1'b0;
         mismatches = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (char_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected char 0x%02h last %0b", $realtime,
                           rsp_bus.payload.code_char, rsp_bus.payload.last_char);
            end else begin
               want = char_due.pop_front();
               if (want.code_char !== rsp_bus.payload.code_char ||
                   want.last_char !== rsp_bus.payload.last_char) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                              $realtime, want.code_char, rsp_bus.payload.code_char,
                              want.last_char, rsp_bus.payload.last_char);
               end
            end
            if (rsp_bus.payload.last_char)
               rsp_calm = ($urandom_range(0, 2) == 0);
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 3);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_bus.ready <= (rsp_wait == 0) && !rsp_hold;
      end
   end

   // one long output stall so the group queue fills and input ready drops
   initial begin
      rsp_hold = 1'b0;
      do @(posedge clock); while (bytes_taken < 50);
      rsp_hold <= 1'b1;
      repeat (90) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      int msg_idx;
      int len;
      // directed: byte extremes, all group sizes, '+' and '/', group + tail
      queue_byte(8'h00, 1'b1, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b1, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b1, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b1, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b1, 1'b0);
      queue_byte(8'hFF, 1'b1, 1'b1, 1'b0);
      queue_byte(8'hFB, 1'b0, 1'b0, 1'b0);
      queue_byte(8'hEF, 1'b0, 1'b0, 1'b0);
      queue_byte(8'hBE, 1'b1, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b1, 1'b0, 1'b0);
      queue_byte(8'h4D, 1'b0, 1'b1, 1'b0);
      queue_byte(8'h61, 1'b0, 1'b1, 1'b0);
      queue_byte(8'h6E, 1'b0, 1'b1, 1'b0);
      queue_byte(8'h4D, 1'b1, 1'b1, 1'b0);
      queue_byte(8'h80, 1'b0, 1'b0, 1'b0);
      queue_byte(8'h01, 1'b0, 1'b0, 1'b0);
      queue_byte(8'h7F, 1'b0, 1'b0, 1'b0);
      queue_byte(8'hFE, 1'b0, 1'b0, 1'b0);
      queue_byte(8'h40, 1'b1, 1'b0, 1'b0);

      // random messages, mostly short, some long ones
      msg_idx = 0;
      while (bytes_to_send.size() < 150) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
         queue_message(len, $urandom_range(0, 3) == 0, msg_idx == 8 || msg_idx == 30);
         msg_idx++;
      end

      do @(posedge clock);
      while (bytes_to_send.size() > 0 || have_beat || req_bus.valid || char_due.size() > 0);
      repeat (10) @(posedge clock);

      if (char_due.size() > 0)
         $display("%0d predicted chars never came out", char_due.size());
      if (mismatches == 0 && char_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d bytes taken, %0d chars still due", bytes_taken,
               char_due.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
